[rtl/core/srr_pkg.sv]
// Shared types, constants and helpers for the suffix rank rebucketing block.
package srr_pkg;

	localparam int MAX_PARTITIONS = 6;
	localparam int VAL_W          = 31;
	localparam int DEST_W         = 3;
	localparam int CFG_IDX_W      = 3;
	localparam int FIFO_DEPTH     = 4;
	localparam int PTR_W          = $clog2(FIFO_DEPTH);
	localparam int FILL_W         = $clog2(FIFO_DEPTH + 1);

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_PARTITION   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PARTITION_COUNT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_0         = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_START_1         = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_START_2         = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_START_3         = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_START_4         = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_START_5         = 3'd7;

	typedef logic [VAL_W-1:0]  val_t;
	typedef logic [DEST_W-1:0] dest_t;

	typedef struct packed {
		dest_t own_partition;
		dest_t partition_count;
		val_t [MAX_PARTITIONS-1:0] starts;
	} cfg_t;

	// One classified word handed from the front to the back
	typedef struct packed {
		val_t  suffix_index;
		dest_t destination;
		logic  first_item;
		logic  same_pair;
	} entry_t;

	function automatic val_t sat_add(val_t a, val_t b);
		logic [VAL_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[VAL_W] ? {VAL_W{1'b1}} : s[VAL_W-1:0];
	endfunction

	function automatic val_t sat_inc(val_t a);
		return (a == {VAL_W{1'b1}}) ? a : a + val_t'(1);
	endfunction

endpackage

[rtl/core/srr_if.sv]
// Channel interfaces: input items, result items and configuration writes.
interface srr_item_if;
	logic                  valid;
	logic                  ready;
	srr_pkg::val_t         key_major;
	srr_pkg::val_t         key_minor;
	srr_pkg::val_t         suffix_index;
	logic                  first_item;

	modport source (output valid, key_major, key_minor, suffix_index, first_item,
		input ready);
	modport sink (input valid, key_major, key_minor, suffix_index, first_item,
		output ready);
endinterface

interface srr_result_if;
	logic                  valid;
	logic                  ready;
	srr_pkg::val_t         bucket_rank;
	srr_pkg::val_t         suffix_out;
	srr_pkg::dest_t        destination;
	srr_pkg::val_t         destination_count;

	modport source (output valid, bucket_rank, suffix_out, destination, destination_count,
		input ready);
	modport sink (input valid, bucket_rank, suffix_out, destination, destination_count,
		output ready);
endinterface

interface srr_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [srr_pkg::CFG_IDX_W-1:0]     index;
	srr_pkg::val_t                     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/srr_front.sv]
// Front end: accept items, compare the key pair and route the suffix index.
module srr_front (
	input  logic                clk,
	input  logic                arst_n,
	srr_item_if.sink            items,
	input  srr_pkg::cfg_t       cfg,
	output srr_pkg::entry_t     push_data,
	output logic                push_valid,
	input  logic                push_ready
);

	srr_pkg::val_t  prev_major_q;
	srr_pkg::val_t  prev_minor_q;
	srr_pkg::dest_t n_active;
	srr_pkg::dest_t dest;
	logic           accept;

	assign items.ready = push_ready;
	assign push_valid  = items.valid;
	assign accept      = items.valid && push_ready;

	always_comb begin
		if (cfg.partition_count == '0)
			n_active = srr_pkg::dest_t'(1);
		else if (cfg.partition_count > srr_pkg::dest_t'(srr_pkg::MAX_PARTITIONS))
			n_active = srr_pkg::dest_t'(srr_pkg::MAX_PARTITIONS);
		else
			n_active = cfg.partition_count;
	end

	// Lowest matching range wins; fall back to the last partition in use
	always_comb begin
		dest = n_active - srr_pkg::dest_t'(1);
		for (int i = srr_pkg::MAX_PARTITIONS - 2; i >= 0; i--) begin
			if ((srr_pkg::dest_t'(i + 1) < n_active) &&
			    (cfg.starts[i] <= items.suffix_index) &&
			    (cfg.starts[i + 1] > items.suffix_index))
				dest = srr_pkg::dest_t'(i);
		end
	end

	always_comb begin
		push_data.suffix_index = items.suffix_index;
		push_data.destination  = dest;
		push_data.first_item   = items.first_item;
		push_data.same_pair    = (items.key_major == prev_major_q) &&
		                         (items.key_minor == prev_minor_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_major_q <= '0;
			prev_minor_q <= '0;
		end else if (accept) begin
			prev_major_q <= items.key_major;
			prev_minor_q <= items.key_minor;
		end
	end

endmodule

[rtl/core/srr_fifo.sv]
// Short queue of classified words between front and back.
module srr_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  srr_pkg::entry_t push_data,
	input  logic            push_valid,
	output logic            push_ready,
	output srr_pkg::entry_t pop_data,
	output logic            pop_valid,
	input  logic            pop_ready
);

	srr_pkg::entry_t                  mem_q [srr_pkg::FIFO_DEPTH];
	logic [srr_pkg::PTR_W-1:0]        wr_ptr_q;
	logic [srr_pkg::PTR_W-1:0]        rd_ptr_q;
	logic [srr_pkg::FILL_W-1:0]       fill_q;
	logic                             push;
	logic                             pop;

	assign push_ready = (fill_q != srr_pkg::FILL_W'(srr_pkg::FIFO_DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + srr_pkg::PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + srr_pkg::PTR_W'(1);
			if (push && !pop)
				fill_q <= fill_q + srr_pkg::FILL_W'(1);
			else if (pop && !push)
				fill_q <= fill_q - srr_pkg::FILL_W'(1);
		end
	end

endmodule

[rtl/core/srr_back.sv]
// Back end: assign bucket ranks, update partition counters, hold the result.
module srr_back (
	input  logic            clk,
	input  logic            arst_n,
	input  srr_pkg::cfg_t   cfg,
	input  srr_pkg::entry_t pop_data,
	input  logic            pop_valid,
	output logic            pop_ready,
	srr_result_if.source    results
);

	srr_pkg::val_t                            prev_rank_q;
	srr_pkg::val_t                            position_q;
	srr_pkg::val_t [srr_pkg::MAX_PARTITIONS-1:0] count_q;
	srr_pkg::val_t [srr_pkg::MAX_PARTITIONS-1:0] count_nxt;
	logic                                     out_valid_q;
	srr_pkg::val_t                            rank_q;
	srr_pkg::val_t                            suffix_q;
	srr_pkg::dest_t                           dest_q;
	srr_pkg::val_t                            dcount_q;
	srr_pkg::dest_t                           own;
	srr_pkg::val_t                            base;
	srr_pkg::val_t                            rank;
	logic                                     pop;

	assign pop_ready = !out_valid_q || results.ready;
	assign pop       = pop_valid && pop_ready;

	always_comb begin
		own = (cfg.own_partition >= srr_pkg::dest_t'(srr_pkg::MAX_PARTITIONS)) ?
		      srr_pkg::dest_t'(srr_pkg::MAX_PARTITIONS - 1) : cfg.own_partition;
		base = cfg.starts[own];
		if (pop_data.first_item)
			rank = base;
		else if (pop_data.same_pair)
			rank = prev_rank_q;
		else
			rank = srr_pkg::sat_add(base, position_q);
	end

	// A new sequence clears every counter before the destination's one is bumped
	always_comb begin
		for (int i = 0; i < srr_pkg::MAX_PARTITIONS; i++) begin
			count_nxt[i] = pop_data.first_item ? '0 : count_q[i];
			if (pop_data.destination == srr_pkg::dest_t'(i))
				count_nxt[i] = srr_pkg::sat_inc(count_nxt[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_rank_q <= '0;
			position_q  <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				prev_rank_q <= rank;
				position_q  <= pop_data.first_item ? srr_pkg::val_t'(1) :
				               srr_pkg::sat_inc(position_q);
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rank_q   <= rank;
			suffix_q <= pop_data.suffix_index;
			dest_q   <= pop_data.destination;
			dcount_q <= count_nxt[pop_data.destination];
		end
	end

	assign results.valid             = out_valid_q;
	assign results.bucket_rank       = rank_q;
	assign results.suffix_out        = suffix_q;
	assign results.destination       = dest_q;
	assign results.destination_count = dcount_q;

endmodule

[rtl/core/suffix_rank_rebucketing.sv]
// An accepted item is queued, then registered as a result once the output register is free.
// Throughput: one item per cycle unless output stalls fill the queue; rank and counters update per item.
// A four-word queue between front and back absorbs up to four items of output stall.
// Reset (arst_n low, asynchronous) clears the previous pair, rank, position, counters,
// queue and output valid, and returns the registers to own 0, count 1, all starts 0.
// Configuration writes are taken every cycle; no clearing pass follows reset.
module suffix_rank_rebucketing (
	input  logic          clk,
	input  logic          arst_n,
	srr_item_if.sink      items,
	srr_result_if.source  results,
	srr_cfg_if.sink       cfg
);

	srr_pkg::cfg_t   cfg_q;
	srr_pkg::entry_t push_data;
	logic            push_valid;
	logic            push_ready;
	srr_pkg::entry_t pop_data;
	logic            pop_valid;
	logic            pop_ready;

	// Configuration words are always taken; the user must write them only while the block is idle (not enforced here)
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_partition   <= '0;
			cfg_q.partition_count <= srr_pkg::dest_t'(1);
			cfg_q.starts          <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index) inside
				srr_pkg::CFG_OWN_PARTITION:
					cfg_q.own_partition <= cfg.data[srr_pkg::DEST_W-1:0];
				srr_pkg::CFG_PARTITION_COUNT:
					cfg_q.partition_count <= cfg.data[srr_pkg::DEST_W-1:0];
				srr_pkg::CFG_START_0, srr_pkg::CFG_START_1, srr_pkg::CFG_START_2,
				srr_pkg::CFG_START_3, srr_pkg::CFG_START_4, srr_pkg::CFG_START_5:
					cfg_q.starts[cfg.index - srr_pkg::CFG_START_0] <= cfg.data;
				default: ;
			endcase
		end
	end

	// Front: compare the pair with the last one and pick the owning partition
	srr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (items),
		.cfg        (cfg_q),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	// Queue: decouple input acceptance from output stalls
	srr_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_data   (pop_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	// Back: rank, position and counter state, plus the output register
	srr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_data  (pop_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.results   (results)
	);

endmodule

[rtl/core/srr_checker.sv]
// Port-level checks for the suffix rank rebucketing block, bound to the top level.
module srr_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input srr_pkg::val_t  bucket_rank,
	input srr_pkg::val_t  suffix_out,
	input srr_pkg::dest_t destination,
	input srr_pkg::val_t  destination_count
);

	// Hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(bucket_rank) &&
		$stable(suffix_out) && $stable(destination) && $stable(destination_count))
		else $error("stalled result changed");

	// A counter has always just been bumped, so it is never zero
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> destination_count != '0)
		else $error("destination count is zero");

	a_dest_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> destination < srr_pkg::dest_t'(srr_pkg::MAX_PARTITIONS))
		else $error("destination out of range");

	// An empty output fills only from an item accepted at the input and passed through the queue
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without an accepted item");

endmodule

bind suffix_rank_rebucketing srr_checker u_srr_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_valid          (items.valid),
	.in_ready          (items.ready),
	.out_valid         (results.valid),
	.out_ready         (results.ready),
	.bucket_rank       (results.bucket_rank),
	.suffix_out        (results.suffix_out),
	.destination       (results.destination),
	.destination_count (results.destination_count)
);

[test/tb.sv]
// Self-checking testbench for the suffix rank rebucketing block.
module tb;

	// Cycles with no word moving on any channel before the run is abandoned
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int REPORT_LIMIT   = 10;
	// Suffix indexes mostly land in this span, where the random starts live
	localparam int INDEX_SPAN     = 4400;
	localparam int NPART          = srr_pkg::MAX_PARTITIONS;
	localparam srr_pkg::val_t VAL_MAX = {srr_pkg::VAL_W{1'b1}};

	typedef struct {
		srr_pkg::val_t key_major;
		srr_pkg::val_t key_minor;
		srr_pkg::val_t suffix_index;
		logic          first_item;
	} item_t;

	typedef struct {
		srr_pkg::val_t  bucket_rank;
		srr_pkg::val_t  suffix_out;
		srr_pkg::dest_t destination;
		srr_pkg::val_t  destination_count;
	} result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic result_accept = 1'b0;

	srr_item_if   item_ch();
	srr_result_if result_ch();
	srr_cfg_if    cfg_ch();

	assign result_ch.ready = result_accept;

	suffix_rank_rebucketing dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (item_ch),
		.results (result_ch),
		.cfg     (cfg_ch)
	);

	always #5 clk = ~clk;

	// Mirror of the registers as last written
	srr_pkg::dest_t mir_own;
	srr_pkg::dest_t mir_count;
	srr_pkg::val_t  mir_starts [NPART];

	// Rebucketing state carried from word to word
	srr_pkg::val_t last_major;
	srr_pkg::val_t last_minor;
	srr_pkg::val_t last_rank;
	srr_pkg::val_t run_pos;
	srr_pkg::val_t part_tally [NPART];

	// Results predicted for accepted items, oldest first
	result_t awaited_ranks [$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int mismatches     = 0;
	int quiet_cycles   = 0;

	// Saturating add at the 31-bit value width
	function automatic srr_pkg::val_t clip_add(srr_pkg::val_t a, srr_pkg::val_t b);
		longint unsigned s;
		s = longint'(a) + longint'(b);
		return (s > longint'(VAL_MAX)) ? VAL_MAX : srr_pkg::val_t'(s);
	endfunction

	// Return the rebucketing state and the register mirror to their reset values
	function automatic void clear_model();
		int i;
		mir_own    = '0;
		mir_count  = srr_pkg::dest_t'(1);
		last_major = '0;
		last_minor = '0;
		last_rank  = '0;
		run_pos    = '0;
		for (i = 0; i < NPART; i++) begin
			mir_starts[i] = '0;
			part_tally[i] = '0;
		end
	endfunction

	// Rank one accepted item, route its suffix and advance the state
	function automatic result_t rebucket(item_t it);
		result_t       r;
		int            own;
		int            n;
		int            d;
		int            i;
		bit            found;
		srr_pkg::val_t base;
		own  = (mir_own > srr_pkg::dest_t'(NPART - 1)) ? NPART - 1 : int'(mir_own);
		base = mir_starts[own];
		if (it.first_item) begin
			// a new sequence clears position and every counter before the item counts
			run_pos = '0;
			for (i = 0; i < NPART; i++)
				part_tally[i] = '0;
			r.bucket_rank = base;
		end else if (it.key_major == last_major && it.key_minor == last_minor) begin
			r.bucket_rank = last_rank;
		end else begin
			r.bucket_rank = clip_add(base, run_pos);
		end
		// zero partitions count as one; anything beyond the maximum is clamped
		n = int'(mir_count);
		if (n < 1)
			n = 1;
		if (n > NPART)
			n = NPART;
		// first range that holds the index wins; the last partition in use catches the rest
		d     = n - 1;
		found = 1'b0;
		for (i = 0; i + 1 < n; i++) begin
			if (!found && mir_starts[i] <= it.suffix_index &&
			    mir_starts[i + 1] > it.suffix_index) begin
				d     = i;
				found = 1'b1;
			end
		end
		part_tally[d] = clip_add(part_tally[d], srr_pkg::val_t'(1));
		last_major = it.key_major;
		last_minor = it.key_minor;
		last_rank  = r.bucket_rank;
		run_pos    = clip_add(run_pos, srr_pkg::val_t'(1));
		r.suffix_out        = it.suffix_index;
		r.destination       = srr_pkg::dest_t'(d);
		r.destination_count = part_tally[d];
		return r;
	endfunction

	function automatic item_t word_of(srr_pkg::val_t maj, srr_pkg::val_t mnr,
		srr_pkg::val_t idx, logic first);
		item_t it;
		it.key_major    = maj;
		it.key_minor    = mnr;
		it.suffix_index = idx;
		it.first_item   = first;
		return it;
	endfunction

	function automatic string describe(result_t r);
		return $sformatf("rank %0d suffix %0d dest %0d count %0d",
			r.bucket_rank, r.suffix_out, r.destination, r.destination_count);
	endfunction

	function automatic void flag_mismatch(string msg);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("%0t: %s", $realtime, msg);
	endfunction

	// Offer one word, idling first at the sender's rate, and hold it until taken
	task automatic send_word(input item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid        <= 1'b1;
		item_ch.key_major    <= it.key_major;
		item_ch.key_minor    <= it.key_minor;
		item_ch.suffix_index <= it.suffix_index;
		item_ch.first_item   <= it.first_item;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		awaited_ranks.push_back(rebucket(it));
	endtask

	// Stop sending and wait for every awaited result, then let the pipeline settle
	task automatic drain_results();
		item_ch.valid <= 1'b0;
		while (awaited_ranks.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write all eight registers in index order; call only while the block is idle
	task automatic write_registers(input srr_pkg::dest_t own, input srr_pkg::dest_t count,
		input srr_pkg::val_t starts [NPART]);
		int r;
		for (r = 0; r < 2 + NPART; r++) begin
			case (r)
				0: begin
					cfg_ch.index <= srr_pkg::CFG_OWN_PARTITION;
					cfg_ch.data  <= srr_pkg::val_t'(own);
				end
				1: begin
					cfg_ch.index <= srr_pkg::CFG_PARTITION_COUNT;
					cfg_ch.data  <= srr_pkg::val_t'(count);
				end
				default: begin
					cfg_ch.index <= srr_pkg::CFG_START_0 + srr_pkg::CFG_IDX_W'(r - 2);
					cfg_ch.data  <= starts[r - 2];
				end
			endcase
			cfg_ch.valid <= 1'b1;
			@(posedge clk);
			while (!cfg_ch.ready)
				@(posedge clk);
		end
		cfg_ch.valid <= 1'b0;
		mir_own   = own;
		mir_count = count;
		for (r = 0; r < NPART; r++)
			mir_starts[r] = starts[r];
	endtask

	// Mostly inside the start ranges, some exactly on a start, some anywhere
	function automatic srr_pkg::val_t pick_index();
		int roll;
		roll = $urandom_range(99);
		if (roll < 10)
			return srr_pkg::val_t'($urandom);
		if (roll < 18)
			return mir_starts[$urandom_range(0, NPART - 1)];
		return srr_pkg::val_t'($urandom_range(0, INDEX_SPAN));
	endfunction

	// Sorted starts with random gaps most of the time, scattered ones otherwise;
	// now and then push the rank base up against the ceiling
	task automatic randomise_registers();
		srr_pkg::dest_t own;
		srr_pkg::dest_t count;
		srr_pkg::val_t  st [NPART];
		int             base;
		int             i;
		own   = srr_pkg::dest_t'($urandom_range(0, 7));
		count = srr_pkg::dest_t'($urandom_range(0, 7));
		if ($urandom_range(99) < 15) begin
			for (i = 0; i < NPART; i++)
				st[i] = srr_pkg::val_t'($urandom_range(0, 4000));
		end else begin
			base = $urandom_range(0, 200);
			for (i = 0; i < NPART; i++) begin
				st[i] = srr_pkg::val_t'(base);
				base += $urandom_range(0, 800);
			end
		end
		if ($urandom_range(9) == 0)
			st[(own > srr_pkg::dest_t'(NPART - 1)) ? NPART - 1 : int'(own)] =
				VAL_MAX - srr_pkg::val_t'($urandom_range(0, 60));
		write_registers(own, count, st);
	endtask

	// Sorted runs opened by a first word, with repeated pairs and random indexes;
	// one pick in ten sends a single noise word instead of a run, and some runs lack their first word
	task automatic run_sequences(input int total, input bit pause_midway);
		int            sent;
		int            len;
		int            k;
		bit            paused;
		srr_pkg::val_t maj;
		srr_pkg::val_t mnr;
		sent   = 0;
		paused = 1'b0;
		while (sent < total) begin
			if (pause_midway && !paused && sent >= total / 2) begin
				drain_results();
				paused = 1'b1;
			end
			if ($urandom_range(9) == 0) begin
				send_word(word_of(srr_pkg::val_t'($urandom), srr_pkg::val_t'($urandom),
					pick_index(), logic'($urandom_range(0, 1))));
				sent++;
				continue;
			end
			len = ($urandom_range(7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 16);
			maj = $urandom_range(0, 1) ? srr_pkg::val_t'($urandom) :
			      srr_pkg::val_t'($urandom_range(0, 40));
			mnr = $urandom_range(0, 1) ? srr_pkg::val_t'($urandom) :
			      srr_pkg::val_t'($urandom_range(0, 40));
			for (k = 0; k < len; k++) begin
				// advance the pair in sorted order unless it repeats
				if (k > 0 && $urandom_range(99) >= 40) begin
					if ($urandom_range(0, 1)) begin
						mnr += srr_pkg::val_t'($urandom_range(1, 500));
					end else begin
						maj += srr_pkg::val_t'($urandom_range(1, 3));
						mnr = srr_pkg::val_t'($urandom_range(0, 100));
					end
				end
				send_word(word_of(maj, mnr, pick_index(), k == 0 && $urandom_range(9) != 0));
				sent++;
			end
		end
	endtask

	// Reset registers and state, no first word: the reset pair (0,0) keeps rank 0
	task automatic test_reset_state();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_word(word_of(0, 0, 0, 1'b0));
		send_word(word_of(0, 0, VAL_MAX, 1'b0));
		send_word(word_of(1, 0, 7, 1'b0));
		send_word(word_of(1, 1, 9, 1'b0));
	endtask

	// Own partition and count above range, top start at the ceiling so ranks saturate,
	// then a single partition with extreme keys and a first word on a repeated pair
	task automatic test_register_extremes();
		srr_pkg::val_t st [NPART];
		drain_results();
		st = '{10, 20, 30, 40, 50, VAL_MAX};
		write_registers(srr_pkg::dest_t'(7), srr_pkg::dest_t'(7), st);
		send_word(word_of(5, 5, 0, 1'b1));
		send_word(word_of(5, 5, 15, 1'b0));
		send_word(word_of(6, 0, VAL_MAX, 1'b0));
		send_word(word_of(7, 0, 45, 1'b0));
		send_word(word_of(7, 1, 50, 1'b0));
		drain_results();
		st = '{0, 0, 0, 0, 0, 0};
		write_registers(srr_pkg::dest_t'(0), srr_pkg::dest_t'(0), st);
		send_word(word_of(VAL_MAX, VAL_MAX, VAL_MAX, 1'b1));
		send_word(word_of(VAL_MAX, VAL_MAX, 0, 1'b1));
		send_word(word_of(VAL_MAX, VAL_MAX, 1, 1'b0));
		send_word(word_of(0, VAL_MAX, 2, 1'b0));
		send_word(word_of(VAL_MAX, 0, 3, 1'b0));
	endtask

	// Starts out of order: the first matching range wins, misses fall to the last
	task automatic test_unsorted_starts();
		srr_pkg::val_t st [NPART];
		drain_results();
		st = '{100, 50, 200, 150, 300, VAL_MAX - 1};
		write_registers(srr_pkg::dest_t'(2), srr_pkg::dest_t'(6), st);
		send_word(word_of(3, 3, 120, 1'b1));
		send_word(word_of(3, 4, 75, 1'b0));
		send_word(word_of(3, 4, 160, 1'b0));
		send_word(word_of(4, 0, 250, 1'b0));
		send_word(word_of(4, 1, 20, 1'b0));
		send_word(word_of(5, 0, 300, 1'b0));
	endtask

	// Four idling regimes, two register settings each; the sender once waits for
	// every result while the receiver is stalling
	task automatic test_random_phases();
		int send_rates [4];
		int recv_rates [4];
		int p;
		int seg;
		send_rates = '{0, 56, 0, 19};
		recv_rates = '{0, 0, 56, 19};
		for (p = 0; p < 4; p++) begin
			for (seg = 0; seg < 2; seg++) begin
				drain_results();
				send_idle_pct  = send_rates[p];
				recv_stall_pct = recv_rates[p];
				randomise_registers();
				run_sequences(190, p == 2 && seg == 0);
			end
		end
	endtask

	// Take result words at the receiver's rate and check each against the oldest prediction
	always @(posedge clk) begin
		result_t got;
		result_t want;
		result_accept <= ($urandom_range(99) >= recv_stall_pct);
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got.bucket_rank       = result_ch.bucket_rank;
			got.suffix_out        = result_ch.suffix_out;
			got.destination       = result_ch.destination;
			got.destination_count = result_ch.destination_count;
			if (awaited_ranks.size() == 0) begin
				flag_mismatch({"result word with nothing awaited: ", describe(got)});
			end else begin
				want = awaited_ranks.pop_front();
				if (got.bucket_rank !== want.bucket_rank ||
				    got.suffix_out !== want.suffix_out ||
				    got.destination !== want.destination ||
				    got.destination_count !== want.destination_count)
					flag_mismatch({"expected ", describe(want), ", got ", describe(got)});
			end
		end
	end

	// Abandon the run once no word has moved on any channel for too long
	always @(posedge clk) begin
		if (!arst_n || (item_ch.valid && item_ch.ready) ||
		    (result_ch.valid && result_ch.ready) || (cfg_ch.valid && cfg_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		arst_n                = 1'b0;
		item_ch.valid        <= 1'b0;
		item_ch.key_major    <= '0;
		item_ch.key_minor    <= '0;
		item_ch.suffix_index <= '0;
		item_ch.first_item   <= 1'b0;
		cfg_ch.valid         <= 1'b0;
		cfg_ch.index         <= srr_pkg::CFG_OWN_PARTITION;
		cfg_ch.data          <= '0;
		clear_model();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_register_extremes();
		test_unsorted_starts();
		test_random_phases();

		drain_results();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
